FILE: rtl/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg: shared types, constants and microcode for the mip chain sizer
// Holds the control word layout, the step program, the block reciprocal
// table and the format register layout used by the sequencer and datapath.
// ----------------------------------------------------------------------------
package tmcs_pkg;

  // Field widths of the input and result items.
  localparam int unsigned WidthW      = 15;
  localparam int unsigned DepthW      = 12;
  localparam int unsigned MipW        = 4;
  localparam int unsigned LayerCountW = 12;
  localparam int unsigned TotalW      = 50;
  localparam int unsigned RowBytesW   = 19;
  localparam int unsigned RowCountW   = 15;
  localparam int unsigned LayerBytesW = 38;
  localparam int unsigned InDataW     = 64;
  localparam int unsigned OutDataW    = 128;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 5;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BYTES_PER_BLOCK = 3'd0,
    CFG_BLOCK_WIDTH     = 3'd1,
    CFG_BLOCK_HEIGHT    = 3'd2,
    CFG_BLOCK_DEPTH     = 3'd3,
    CFG_MIN_BLOCKS_X    = 3'd4,
    CFG_MIN_BLOCKS_Y    = 3'd5,
    CFG_MIN_BLOCKS_Z    = 3'd6,
    CFG_IS_COMPRESSED   = 3'd7
  } cfg_idx_e;

  // Format registers as seen by the datapath.
  typedef struct packed {
    logic [4:0] bytes_per_block;
    logic [3:0] block_width;
    logic [3:0] block_height;
    logic [3:0] block_depth;
    logic [1:0] min_blocks_x;
    logic [1:0] min_blocks_y;
    logic [1:0] min_blocks_z;
    logic       is_compressed;
  } cfg_t;

  // Program steps; the step counter walks these in order unless it jumps.
  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_INIT = 4'd1,
    ST_AX   = 4'd2,
    ST_FX   = 4'd3,
    ST_AY   = 4'd4,
    ST_FY   = 4'd5,
    ST_AZ   = 4'd6,
    ST_FZ   = 4'd7,
    ST_XY   = 4'd8,
    ST_ZB   = 4'd9,
    ST_RB   = 4'd10,
    ST_ZP   = 4'd11,
    ST_LY   = 4'd12,
    ST_TERM = 4'd13,
    ST_ACC  = 4'd14,
    ST_DONE = 4'd15
  } step_e;

  // First multiplier operand.
  typedef enum logic [2:0] {
    OPA_LAYERS,
    OPA_NCALC,
    OPA_UX,
    OPA_UZ,
    OPA_XY
  } opa_e;

  // Second multiplier operand.
  typedef enum logic [2:0] {
    OPB_BPB,
    OPB_RECIP,
    OPB_UY,
    OPB_BL,
    OPB_ZP,
    OPB_ZB
  } opb_e;

  // Register that takes the product.
  typedef enum logic [3:0] {
    DST_NONE,
    DST_BL,
    DST_P,
    DST_XY,
    DST_ZB,
    DST_ROWB,
    DST_ZP,
    DST_LAYER,
    DST_TERM
  } dst_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Jump conditions; a true condition loads the target, else the counter steps.
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_IN_WAIT,
    COND_LEVEL_NZ,
    COND_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    opa_e  opa;
    opb_e  opb;
    dst_e  dst;
    axis_e axis;
    logic  fix;
    logic  init;
    logic  acc;
    logic  emit;
    cond_e cond;
    step_e target;
  } ctrl_word_t;

  // Status fed back from the datapath to the sequencer.
  typedef struct packed {
    logic level_nz;
    logic more;
  } stat_t;

  // Results of one item.
  typedef struct packed {
    logic [LayerBytesW-1:0] layer_bytes;
    logic [RowCountW-1:0]   row_count;
    logic [RowBytesW-1:0]   row_bytes;
    logic [TotalW-1:0]      total_bytes;
  } result_t;

  // Assembles one control word.
  function automatic ctrl_word_t cw(opa_e a, opb_e b, dst_e d, axis_e ax, logic fx,
                                    logic in, logic ac, logic em, cond_e c, step_e t);
    ctrl_word_t w;
    w.opa    = a;
    w.opb    = b;
    w.dst    = d;
    w.axis   = ax;
    w.fix    = fx;
    w.init   = in;
    w.acc    = ac;
    w.emit   = em;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // The program. Each axis takes two steps: a reciprocal multiply for the
  // block count, then a correction and the minimum-block floor. The base
  // level outputs are only formed on the first pass of the level loop.
  function automatic ctrl_word_t ucode(step_e s);
    ctrl_word_t w;
    unique case (s)
      ST_IDLE: w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_IN_WAIT, ST_IDLE);
      ST_INIT: w = cw(OPA_LAYERS, OPB_BPB, DST_BL, AXIS_X, 1'b0, 1'b1, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_AX:   w = cw(OPA_NCALC, OPB_RECIP, DST_P, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_FX:   w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_X, 1'b1, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_AY:   w = cw(OPA_NCALC, OPB_RECIP, DST_P, AXIS_Y, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_FY:   w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_Y, 1'b1, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_AZ:   w = cw(OPA_NCALC, OPB_RECIP, DST_P, AXIS_Z, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_FZ:   w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_Z, 1'b1, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_XY:   w = cw(OPA_UX, OPB_UY, DST_XY, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_ZB:   w = cw(OPA_UZ, OPB_BL, DST_ZB, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_LEVEL_NZ, ST_TERM);
      ST_RB:   w = cw(OPA_UX, OPB_BPB, DST_ROWB, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_ZP:   w = cw(OPA_UZ, OPB_BPB, DST_ZP, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_LY:   w = cw(OPA_XY, OPB_ZP, DST_LAYER, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_TERM: w = cw(OPA_XY, OPB_ZB, DST_TERM, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b0,
                      COND_NEXT, ST_IDLE);
      ST_ACC:  w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_X, 1'b0, 1'b0, 1'b1, 1'b0,
                      COND_MORE, ST_AX);
      ST_DONE: w = cw(OPA_UX, OPB_UY, DST_NONE, AXIS_X, 1'b0, 1'b0, 1'b0, 1'b1,
                      COND_OUT_BUSY, ST_DONE);
    endcase
    return w;
  endfunction

  // Floor of 2^16 over the block size; a block size of zero acts as one.
  function automatic logic [16:0] recip(logic [3:0] b);
    logic [16:0] r;
    unique case (b)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65536;
      4'd2:  r = 17'd32768;
      4'd3:  r = 17'd21845;
      4'd4:  r = 17'd16384;
      4'd5:  r = 17'd13107;
      4'd6:  r = 17'd10922;
      4'd7:  r = 17'd9362;
      4'd8:  r = 17'd8192;
      4'd9:  r = 17'd7281;
      4'd10: r = 17'd6553;
      4'd11: r = 17'd5957;
      4'd12: r = 17'd5461;
      4'd13: r = 17'd5041;
      4'd14: r = 17'd4681;
      4'd15: r = 17'd4369;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tmcs_datapath.sv
// ----------------------------------------------------------------------------
// tmcs_datapath: arithmetic of the mip chain sizer
// One shared 32x32 multiplier, an axis unit that forms block counts by a
// reciprocal multiply and a one-step correction, and the level accumulator.
// Working registers are loaded under the control word of the sequencer.
// ----------------------------------------------------------------------------
module tmcs_datapath #(
  parameter int unsigned DIM_BITS = 15,
  parameter int unsigned MAX_MIPS = 15
) (
  input  logic                                  clk_i,
  input  tmcs_pkg::ctrl_word_t                  ctrl_i,
  input  tmcs_pkg::cfg_t                        cfg_i,
  input  logic                                  load_i,
  input  logic [tmcs_pkg::WidthW-1:0]           base_width_i,
  input  logic [tmcs_pkg::WidthW-1:0]           base_height_i,
  input  logic [tmcs_pkg::DepthW-1:0]           base_depth_i,
  input  logic [tmcs_pkg::MipW-1:0]             mip_count_i,
  input  logic [tmcs_pkg::LayerCountW-1:0]      layer_count_i,
  output tmcs_pkg::stat_t                       stat_o,
  output tmcs_pkg::result_t                     result_o
);

  import tmcs_pkg::*;

  // Width and height keep at most their low DIM_BITS bits; mips are capped.
  localparam int unsigned DimKeep  = (DIM_BITS > WidthW) ? WidthW : DIM_BITS;
  localparam logic [WidthW:0] DimMaskWide = (WidthW+1)'((32'd1 << DimKeep) - 32'd1);
  localparam logic [WidthW-1:0] DimMask = DimMaskWide[WidthW-1:0];
  localparam int unsigned MipLimit = (MAX_MIPS > 15) ? 15 : MAX_MIPS;
  localparam logic [MipW-1:0] MipCap = MipW'(MipLimit);

  // Captured item.
  logic [WidthW-1:0]      w_q, h_q;
  logic [DepthW-1:0]      d_q;
  logic [MipW-1:0]        mips_q;
  logic [LayerCountW-1:0] lay_q;

  // Working registers.
  logic [MipW-1:0]         lvl_q;
  logic [15:0]             n_q;
  logic [WidthW-1:0]       dl_q;
  logic [32:0]             p_q;
  logic [WidthW-1:0]       ux_q, uy_q;
  logic [DepthW-1:0]       uz_q;
  logic [16:0]             bl_q;
  logic [29:0]             xy_q;
  logic [28:0]             zb_q;
  logic [16:0]             zp_q;
  logic [58:0]             term_q;
  logic [TotalW-1:0]       acc_q;
  logic                    ovf_q;
  logic [RowBytesW-1:0]    rowb_q;
  logic [RowCountW-1:0]    rowc_q;
  logic [LayerBytesW-1:0]  layer_q;

  // Axis selection for the block count steps.
  logic [WidthW-1:0] base;
  logic [3:0]        blk;
  logic [1:0]        minb;
  always_comb begin
    case (ctrl_i.axis)
      AXIS_X: begin
        base = w_q;
        blk  = cfg_i.block_width;
        minb = cfg_i.min_blocks_x;
      end
      AXIS_Y: begin
        base = h_q;
        blk  = cfg_i.block_height;
        minb = cfg_i.min_blocks_y;
      end
      default: begin
        base = {{(WidthW-DepthW){1'b0}}, d_q};
        blk  = cfg_i.block_depth;
        minb = cfg_i.min_blocks_z;
      end
    endcase
  end

  // Level dimension, raised to one, and the numerator of the rounded-up count.
  logic [WidthW-1:0] shifted, dlev;
  logic [3:0]        beff;
  logic [15:0]       ncalc;
  assign shifted = base >> lvl_q;
  assign dlev    = (shifted == '0) ? WidthW'(1) : shifted;
  assign beff    = (blk == 4'd0) ? 4'd1 : blk;
  assign ncalc   = 16'(dlev) + 16'(beff) - 16'd1;

  // Correction of the reciprocal quotient, which is low by at most one.
  logic [15:0] q0, rem, qc, units;
  logic [19:0] qb;
  assign q0    = p_q[31:16];
  assign qb    = 20'(q0) * 20'(beff);
  assign rem   = n_q - qb[15:0];
  assign qc    = q0 + 16'(rem >= 16'(beff));
  assign units = !cfg_i.is_compressed ? 16'(dl_q) :
                 (qc < 16'(minb)) ? 16'(minb) : qc;

  // Shared multiplier operands.
  logic [31:0] a_op, b_op;
  logic [63:0] prod;
  always_comb begin
    case (ctrl_i.opa)
      OPA_LAYERS: a_op = 32'(lay_q);
      OPA_NCALC:  a_op = 32'(ncalc);
      OPA_UX:     a_op = 32'(ux_q);
      OPA_UZ:     a_op = 32'(uz_q);
      OPA_XY:     a_op = 32'(xy_q);
      default:    a_op = '0;
    endcase
    case (ctrl_i.opb)
      OPB_BPB:   b_op = 32'(cfg_i.bytes_per_block);
      OPB_RECIP: b_op = 32'(recip(blk));
      OPB_UY:    b_op = 32'(uy_q);
      OPB_BL:    b_op = 32'(bl_q);
      OPB_ZP:    b_op = 32'(zp_q);
      OPB_ZB:    b_op = 32'(zb_q);
      default:   b_op = '0;
    endcase
  end
  assign prod = {32'd0, a_op} * {32'd0, b_op};

  // Accumulation of one level term, with a sticky overflow.
  logic [TotalW:0] sum;
  assign sum = {1'b0, acc_q} + {1'b0, term_q[TotalW-1:0]};

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      w_q    <= base_width_i & DimMask;
      h_q    <= base_height_i & DimMask;
      d_q    <= base_depth_i;
      mips_q <= (mip_count_i > MipCap) ? MipCap : mip_count_i;
      lay_q  <= layer_count_i;
    end
  end

  // Product destinations.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.dst)
      DST_NONE: ;
      DST_BL:   bl_q <= prod[16:0];
      DST_P: begin
        p_q  <= prod[32:0];
        n_q  <= ncalc;
        dl_q <= dlev;
      end
      DST_XY:   xy_q <= prod[29:0];
      DST_ZB:   zb_q <= prod[28:0];
      DST_ROWB: begin
        rowb_q <= (|prod[63:RowBytesW]) ? '1 : prod[RowBytesW-1:0];
        rowc_q <= uy_q;
      end
      DST_ZP:    zp_q <= prod[16:0];
      DST_LAYER: layer_q <= (|prod[63:LayerBytesW]) ? '1 : prod[LayerBytesW-1:0];
      DST_TERM:  term_q <= prod[58:0];
      default: ;
    endcase
  end

  // Axis unit results.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.fix) begin
      case (ctrl_i.axis)
        AXIS_X:  ux_q <= units[WidthW-1:0];
        AXIS_Y:  uy_q <= units[WidthW-1:0];
        default: uz_q <= units[DepthW-1:0];
      endcase
    end
  end

  // Level counter and total.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      lvl_q <= '0;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.acc) begin
      lvl_q <= lvl_q + MipW'(1);
      if (lvl_q < mips_q) begin
        acc_q <= sum[TotalW-1:0];
        ovf_q <= ovf_q | sum[TotalW] | (|term_q[58:TotalW]);
      end
    end
  end

  assign stat_o.level_nz = (lvl_q != '0);
  assign stat_o.more     = (({1'b0, lvl_q} + 5'd1) < {1'b0, mips_q});

  assign result_o.total_bytes = ovf_q ? '1 : acc_q;
  assign result_o.row_bytes   = rowb_q;
  assign result_o.row_count   = rowc_q;
  assign result_o.layer_bytes = layer_q;

endmodule

FILE: rtl/texture_mip_chain_size_core.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_size_core: byte size of a texture mip chain
// Microcoded sequencer over a shared datapath: sums the layer bytes of each
// mip level times the layer count, and reports base level row and layer sizes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         one region description per item
//  m_axis    out        one size result per item
//  cfg       in         format register writes, no read-back
//
// From acceptance to its result being offered, an item runs its program over
// L = max(1, min(mip_count, MAX_MIPS)) levels; each level runs ten program
// steps on the one shared multiplier, the base level three more.
// A new item is accepted only when the sequencer is back in its idle step;
// a result waits in the output register and a stalled result holds the
// program in its final step. Reset loads the format defaults and idles.
//
module texture_mip_chain_size_core #(
  parameter int unsigned DIM_BITS = 15,
  parameter int unsigned MAX_MIPS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Fields from bit 0: base_width[14:0], base_height[29:15], base_depth[41:30],
  // mip_count[45:42], layer_count[57:46], zero fill.
  input  logic [tmcs_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: total_bytes[49:0], row_bytes[68:50], row_count[83:69],
  // layer_bytes[121:84], zero fill.
  output logic [tmcs_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [tmcs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tmcs_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  import tmcs_pkg::*;

  cfg_t       cfg_q;
  step_e      pc_q, pc_d;
  ctrl_word_t ctrl;
  stat_t      stat;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q;
  logic       in_fire, out_busy, jump;

  // Format registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_block <= 5'd4;
      cfg_q.block_width     <= 4'd1;
      cfg_q.block_height    <= 4'd1;
      cfg_q.block_depth     <= 4'd1;
      cfg_q.min_blocks_x    <= 2'd1;
      cfg_q.min_blocks_y    <= 2'd1;
      cfg_q.min_blocks_z    <= 2'd1;
      cfg_q.is_compressed   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BYTES_PER_BLOCK: cfg_q.bytes_per_block <= cfg_wdata_i;
        CFG_BLOCK_WIDTH:     cfg_q.block_width     <= cfg_wdata_i[3:0];
        CFG_BLOCK_HEIGHT:    cfg_q.block_height    <= cfg_wdata_i[3:0];
        CFG_BLOCK_DEPTH:     cfg_q.block_depth     <= cfg_wdata_i[3:0];
        CFG_MIN_BLOCKS_X:    cfg_q.min_blocks_x    <= cfg_wdata_i[1:0];
        CFG_MIN_BLOCKS_Y:    cfg_q.min_blocks_y    <= cfg_wdata_i[1:0];
        CFG_MIN_BLOCKS_Z:    cfg_q.min_blocks_z    <= cfg_wdata_i[1:0];
        CFG_IS_COMPRESSED:   cfg_q.is_compressed   <= cfg_wdata_i[0];
      endcase
    end
  end

  // Control word of the current step.
  assign ctrl          = ucode(pc_q);
  assign s_axis_tready = (pc_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;

  // Jump decision; the last step falls through to the idle step by wrap-around.
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_IN_WAIT:  jump = !in_fire;
      COND_LEVEL_NZ: jump = stat.level_nz;
      COND_MORE:     jump = stat.more;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? ctrl.target : step_e'(4'(pc_q + 4'd1));
  end

  // Step counter and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (ctrl.emit && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ctrl.emit && !out_busy) begin
      out_q <= result;
    end
  end

  tmcs_datapath #(
    .DIM_BITS (DIM_BITS),
    .MAX_MIPS (MAX_MIPS)
  ) u_datapath (
    .clk_i         (clk_i),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .load_i        (in_fire),
    .base_width_i  (s_axis_tdata[14:0]),
    .base_height_i (s_axis_tdata[29:15]),
    .base_depth_i  (s_axis_tdata[41:30]),
    .mip_count_i   (s_axis_tdata[45:42]),
    .layer_count_i (s_axis_tdata[57:46]),
    .stat_o        (stat),
    .result_o      (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.layer_bytes, out_q.row_count, out_q.row_bytes,
                          out_q.total_bytes};

endmodule
